FILE: rtl/cvra_pkg.sv
// Shared constants, codes and types for the contiguous value run allocator.
// Used by cvra_cell, cvra_ctrl and the top level; depends on nothing.
package cvra_pkg;

	// Window capacity and derived widths
	localparam int SLOTS = 64;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Fixed field widths
	localparam int VAL_W = 16;
	localparam int LEN_W = 7;
	localparam int OP_W  = 2;
	localparam int CMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX = 1'd1;

	// Scan wavefront handed from cell to cell
	typedef struct packed {
		logic             active;
		logic [CNT_W-1:0] run;
	} wave_t;

	// Broadcast command from the controller to every cell
	typedef struct packed {
		logic             clear;
		logic             mark;
		logic [IDX_W-1:0] mark_idx;
		logic             fill;
		logic [IDX_W-1:0] fill_lo;
		logic [IDX_W-1:0] fill_hi;
		logic             launch;
		logic             kill;
		logic [LEN_W-1:0] len;
	} cell_cmd_t;

endpackage

FILE: rtl/cvra_cell.sv
// One slot of the usage bitmap plus one stage of the free-run scan wavefront.
// Depends on cvra_pkg.
module cvra_cell
	import cvra_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] index,
	input  cell_cmd_t        cmd,
	input  wave_t            wave_in,
	output wave_t            wave_out,
	output logic             hit
);

	logic             used_q;
	wave_t            wave_q;
	logic [CNT_W-1:0] run_new;

	// Extend or restart the free run at this slot
	assign run_new = used_q ? '0 : wave_in.run + CNT_W'(1);
	assign hit     = wave_in.active && (CMP_W'(run_new) == CMP_W'(cmd.len));
	assign wave_out = wave_q;

	// Hold the used bit; clear, mark or fill it on command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (cmd.clear) begin
			used_q <= 1'b0;
		end else if (cmd.mark && cmd.mark_idx == index) begin
			used_q <= 1'b1;
		end else if (cmd.fill && index >= cmd.fill_lo && index <= cmd.fill_hi) begin
			used_q <= 1'b1;
		end
	end

	// Advance the wavefront to the next cell; drop it when the scan ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q.active <= wave_in.active & ~cmd.kill;
			wave_q.run    <= run_new;
		end
	end

endmodule

FILE: rtl/cvra_ctrl.sv
// Sequencer for the allocator: configuration registers, item handshake,
// window checks, scan control and the result register. Depends on cvra_pkg.
module cvra_ctrl
	import cvra_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [OP_W-1:0]      op,
	input  logic [VAL_W-1:0]     used_value,
	input  logic [LEN_W-1:0]     run_length,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 status,
	output logic [VAL_W-1:0]     start_value,
	output cell_cmd_t            cmd,
	input  logic [SLOTS-1:0]     hit
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [LEN_W-1:0] len_q;
	logic [VAL_W-1:0] min_q, max_q;
	logic             res_valid_q;
	logic             res_status_q;
	logic [VAL_W-1:0] res_start_q;
	logic             pend_status_q;
	logic [VAL_W-1:0] pend_start_q;

	logic [VAL_W+1:0] win_diff;
	logic [CNT_W-1:0] win_n;
	logic [VAL_W:0]   mark_off;
	logic             mark_ok;
	logic             len_ok;
	logic             accept;
	logic             out_free;
	logic             scan_last;
	logic [IDX_W-1:0] run_lo;
	logic             fin;
	logic             fin_status;
	logic [VAL_W-1:0] fin_start;
	logic             load_res;
	logic             load_pend;

	// Window size, clamped to 0..SLOTS
	assign win_diff = {{2{max_q[VAL_W-1]}}, max_q} - {{2{min_q[VAL_W-1]}}, min_q}
		+ (VAL_W+2)'(1);
	always_comb begin
		if (win_diff[VAL_W+1]) begin
			win_n = '0;
		end else if (win_diff > (VAL_W+2)'(SLOTS)) begin
			win_n = CNT_W'(SLOTS);
		end else begin
			win_n = win_diff[CNT_W-1:0];
		end
	end

	// Mark offset inside the window, run length against the window
	assign mark_off = {used_value[VAL_W-1], used_value} - {min_q[VAL_W-1], min_q};
	assign mark_ok  = !mark_off[VAL_W] && (mark_off < (VAL_W+1)'(win_n));
	assign len_ok   = (run_length != '0) && (CMP_W'(run_length) <= CMP_W'(win_n));

	assign accept     = item_valid && (state_q == ST_IDLE);
	assign item_stall = (state_q != ST_IDLE);
	assign out_free   = !res_valid_q || !result_stall;
	assign scan_last  = (CNT_W'(idx_q) + CNT_W'(1)) == win_n;
	assign run_lo     = idx_q - IDX_W'(len_q) + IDX_W'(1);

	// Issue cell commands and decide the result of the current item
	always_comb begin
		cmd          = '0;
		cmd.len      = len_q;
		cmd.mark_idx = mark_off[IDX_W-1:0];
		cmd.fill_lo  = run_lo;
		cmd.fill_hi  = idx_q;
		fin          = 1'b0;
		fin_status   = 1'b0;
		fin_start    = '0;
		state_d      = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_CLEAR: begin
							cmd.clear = 1'b1;
							fin       = 1'b1;
						end
						OP_MARK: begin
							cmd.mark   = mark_ok;
							fin        = 1'b1;
							fin_status = !mark_ok;
						end
						OP_ALLOC: begin
							if (len_ok) begin
								state_d = ST_SCAN;
							end else begin
								fin        = 1'b1;
								fin_status = 1'b1;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.launch = (idx_q == '0);
				if (|hit) begin
					cmd.fill  = 1'b1;
					cmd.kill  = 1'b1;
					fin       = 1'b1;
					fin_start = min_q + VAL_W'(run_lo);
				end else if (scan_last) begin
					cmd.kill   = 1'b1;
					fin        = 1'b1;
					fin_status = 1'b1;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_HOLD;
		end
	end

	assign load_res  = fin && out_free;
	assign load_pend = (state_q == ST_HOLD) && out_free;

	// Advance state, scan index and captured run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
				len_q <= run_length;
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= VAL_W'(0);
			max_q <= VAL_W'(63);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN: min_q <= cfg_data;
				CFG_MAX: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Result register and the parked result while the output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res || load_pend) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_status_q <= fin_status;
			res_start_q  <= fin_start;
		end else if (load_pend) begin
			res_status_q <= pend_status_q;
			res_start_q  <= pend_start_q;
		end
		if (fin && !out_free) begin
			pend_status_q <= fin_status;
			pend_start_q  <= fin_start;
		end
	end

	assign result_valid = res_valid_q;
	assign status       = res_status_q;
	assign start_value  = res_start_q;

endmodule

FILE: rtl/contiguous_value_run_allocator.sv
// Top level of the contiguous value run allocator: controller plus a chain
// of bitmap cells. Depends on cvra_pkg, cvra_cell and cvra_ctrl.
//
// First-fit allocator over a usage bitmap of SLOTS values starting at
// min_value. Each transferred item gives exactly one result. Some items
// finish in the transfer cycle: a clear, a mark, an unused op code, and an
// allocate item whose run length is zero or longer than the window. Their
// result is registered at the transfer edge and is offered from the next
// cycle, or is parked while a stalled result holds the output register.
// Any other allocate item launches a scan wavefront that moves through the
// cell chain one slot per cycle. Its result is decided when the wavefront
// reaches the slot at which the run completes, or, when no run is found,
// the last slot of the window (at most SLOTS values). On a hit the run is
// marked used at the edge that registers or parks the result. item_stall is
// high while a scan runs, and while a finished result waits behind a stalled
// one. One result may sit in the output register under result_stall while
// the next item is transferred in. The bitmap resets to all free at once,
// with no clearing pass. Write configuration only while the block is idle.
module contiguous_value_run_allocator
	import cvra_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [OP_W-1:0]      op,
	input  logic [VAL_W-1:0]     used_value,
	input  logic [LEN_W-1:0]     run_length,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 status,
	output logic [VAL_W-1:0]     start_value
);

	cell_cmd_t        cmd;
	logic [SLOTS-1:0] hit;
	wave_t            wave [SLOTS+1];

	cvra_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.used_value   (used_value),
		.run_length   (run_length),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.start_value  (start_value),
		.cmd          (cmd),
		.hit          (hit)
	);

	// Launch the wavefront into the first cell
	assign wave[0].active = cmd.launch;
	assign wave[0].run    = '0;

	// Chain of bitmap cells, each handing the wavefront to its neighbor
	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		cvra_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.index    (IDX_W'(k)),
			.cmd      (cmd),
			.wave_in  (wave[k]),
			.wave_out (wave[k+1]),
			.hit      (hit[k])
		);
	end

endmodule
